/* hw/rtl/lmewp_pkg.sv */
// ----------------------------------------------------------------------------
// List-mode event word parser package
// Shared types and constants for the word queue, the framer and the top level.
// ----------------------------------------------------------------------------
package lmewp_pkg;

    localparam int WORD_W   = 32;
    localparam int Q_DEPTH  = 2;

    localparam logic [31:0] PHYSICS_TYPE    = 32'd30;
    localparam logic [31:0] MIN_BODY_BYTES  = 32'd48;
    localparam logic [31:0] PRE_EVENT_WORDS = 32'd14;
    localparam logic [31:0] BODY_HDR_WORDS  = 32'd5;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_ENERGY = 2'd1;
    localparam logic [1:0] KIND_QDC    = 2'd2;

    localparam logic [1:0] CFG_WRAPPED = 2'd0;
    localparam logic [1:0] CFG_LENGTHS = 2'd1;

    // one result record as it travels to the output stage
    typedef struct packed {
        logic [1:0]  record_kind;
        logic [31:0] event_number;
        logic [11:0] source_id;
        logic [4:0]  header_length;
        logic [13:0] event_length;
        logic        pileup;
        logic [47:0] timestamp;
        logic [15:0] cfd_word;
        logic [15:0] energy;
        logic [15:0] trace_info;
        logic [2:0]  sum_index;
        logic [31:0] sum_value;
    } t_record;

endpackage

/* hw/rtl/lmewp_queue.sv */
// ----------------------------------------------------------------------------
// Word queue
// Short FIFO between the input front and the framing back end.
// ----------------------------------------------------------------------------
module lmewp_queue #(
    parameter int DEPTH = lmewp_pkg::Q_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_data
);
    import lmewp_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [31:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          wr, rd;

    assign o_ready = (r_cnt != (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;

    // storage
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end

endmodule

/* hw/rtl/lmewp_framer.sv */
// ----------------------------------------------------------------------------
// Framer back end
// Walks ring items and events one word at a time and builds records.
// ----------------------------------------------------------------------------
module lmewp_framer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wrapped,
    input  logic                 i_lengths,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [31:0]          i_word,
    output logic                 o_valid,
    input  logic                 i_ready,
    output lmewp_pkg::t_record   o_rec
);
    import lmewp_pkg::*;

    localparam logic [3:0] PH_START   = 4'd0;
    localparam logic [3:0] PH_RSIZE   = 4'd1;
    localparam logic [3:0] PH_RTYPE   = 4'd2;
    localparam logic [3:0] PH_RSKIP   = 4'd3;
    localparam logic [3:0] PH_RBH     = 4'd4;
    localparam logic [3:0] PH_BSIZE   = 4'd5;
    localparam logic [3:0] PH_BSKIP   = 4'd6;
    localparam logic [3:0] PH_PRESKIP = 4'd7;
    localparam logic [3:0] PH_H0      = 4'd8;
    localparam logic [3:0] PH_H1      = 4'd9;
    localparam logic [3:0] PH_H2      = 4'd10;
    localparam logic [3:0] PH_H3      = 4'd11;
    localparam logic [3:0] PH_EXTRA   = 4'd12;
    localparam logic [3:0] PH_TSKIP   = 4'd13;

    logic [3:0]  r_phase, n_phase;
    logic [31:0] r_left, n_left;
    logic [31:0] r_bsize, n_bsize;
    logic [31:0] r_bused, n_bused;
    logic [31:0] r_h0, r_h1, r_h2;
    logic [31:0] r_evt, n_evt;
    logic [4:0]  r_xidx, n_xidx;
    logic [4:0]  r_hl, n_hl;
    logic        r_ovalid;
    t_record     r_rec, n_rec;
    logic        n_emit;
    logic        take;

    logic [3:0]  ph;
    logic        last;
    logic [4:0]  hl_w;
    logic [13:0] el_w, el_h;
    logic [14:0] tlen;
    logic [31:0] k;

    // output register frees as soon as it is taken
    assign o_ready = !r_ovalid || i_ready;
    assign take    = i_valid && o_ready;
    assign o_valid = r_ovalid;
    assign o_rec   = r_rec;

    always_comb begin
        n_phase = r_phase;
        n_left  = r_left;
        n_bsize = r_bsize;
        n_bused = r_bused;
        n_evt   = r_evt;
        n_xidx  = r_xidx;
        n_hl    = r_hl;
        n_rec   = '0;
        n_emit  = 1'b0;
        k       = '0;
        hl_w    = r_h0[16:12];
        el_w    = r_h0[30:17];
        el_h    = r_h0[30:17];
        tlen    = i_word[30:16];
        last    = (r_left <= 32'd1);

        // resolve the start of an item
        ph = r_phase;
        if (r_phase == PH_START) begin
            if (!i_wrapped) begin
                ph = PH_H0;
            end else if (r_bused < r_bsize && r_bsize > MIN_BODY_BYTES) begin
                ph = PH_PRESKIP;
                n_left = PRE_EVENT_WORDS;
                last = 1'b0;
            end else begin
                ph = PH_RSIZE;
            end
        end

        unique case (ph)
            PH_RSIZE: begin
                n_left  = i_word;
                n_phase = PH_RTYPE;
            end
            PH_RTYPE: begin
                if (i_word == PHYSICS_TYPE) begin
                    n_left  = BODY_HDR_WORDS;
                    n_phase = PH_RBH;
                end else begin
                    k = (r_left >= 32'd8) ? ((r_left - 32'd8) >> 2) : '0;
                    n_left  = k;
                    n_phase = (k != '0) ? PH_RSKIP : PH_RSIZE;
                end
            end
            PH_RSKIP, PH_RBH, PH_BSKIP, PH_TSKIP: begin
                if (ph == PH_TSKIP) begin
                    n_bused = r_bused + 32'd4;
                end
                if (last) begin
                    n_left = '0;
                    unique case (ph)
                        PH_RSKIP: n_phase = PH_RSIZE;
                        PH_RBH:   n_phase = PH_BSIZE;
                        default:  n_phase = PH_START;
                    endcase
                end else begin
                    n_left = r_left - 32'd1;
                end
            end
            PH_BSIZE: begin
                n_bsize = i_word;
                n_bused = 32'd4;
                if (i_word > MIN_BODY_BYTES) begin
                    n_phase = PH_START;
                end else begin
                    k = (i_word > 32'd4) ? ((i_word - 32'd4) >> 2) : '0;
                    n_bused = i_word;
                    n_left  = k;
                    n_phase = (k != '0) ? PH_BSKIP : PH_START;
                end
            end
            PH_PRESKIP: begin
                n_bused = r_bused + 32'd4;
                if (r_phase == PH_START) begin
                    n_left  = PRE_EVENT_WORDS - 32'd1;
                    n_phase = PH_PRESKIP;
                end else if (last) begin
                    n_left  = '0;
                    n_phase = PH_H0;
                end else begin
                    n_left  = r_left - 32'd1;
                    n_phase = PH_PRESKIP;
                end
            end
            PH_H0, PH_H1, PH_H2: begin
                n_bused = r_bused + 32'd4;
                n_phase = ph + 4'd1;
            end
            PH_H3: begin
                n_bused = r_bused + 32'd4;
                n_evt   = r_evt + 32'd1;
                n_emit  = 1'b1;
                n_rec.record_kind   = KIND_HEADER;
                n_rec.header_length = hl_w;
                n_rec.event_length  = el_w;
                n_hl = hl_w;
                if (i_lengths) begin
                    n_rec.trace_info = {1'b0, tlen};
                    k = (el_w > 14'd4) ? 32'(el_w - 14'd4) : '0;
                    n_left  = k;
                    n_phase = (k != '0) ? PH_TSKIP : PH_START;
                end else begin
                    n_rec.event_number = r_evt + 32'd1;
                    n_rec.source_id    = r_h0[11:0];
                    n_rec.pileup       = r_h0[31];
                    n_rec.timestamp    = {r_h2[15:0], r_h1};
                    n_rec.cfd_word     = r_h2[31:16];
                    n_rec.energy       = i_word[15:0];
                    n_rec.trace_info   = {i_word[31],
                                          (14'(el_w) > 14'(hl_w)) ? 15'd0 : tlen};
                    n_xidx = '0;
                    if (hl_w > 5'd4) begin
                        n_left  = 32'(hl_w - 5'd4);
                        n_phase = PH_EXTRA;
                    end else begin
                        k = (el_w > 14'(hl_w)) ? 32'(el_w - 14'(hl_w)) : '0;
                        n_left  = k;
                        n_phase = (k != '0) ? PH_TSKIP : PH_START;
                    end
                end
            end
            PH_EXTRA: begin
                n_bused = r_bused + 32'd4;
                n_rec.event_number = r_evt;
                n_rec.sum_value    = i_word;
                if ((r_hl == 5'd8 || r_hl == 5'd16) && r_xidx < 5'd4) begin
                    n_emit = 1'b1;
                    n_rec.record_kind = KIND_ENERGY;
                    n_rec.sum_index   = r_xidx[2:0];
                end else if (r_hl == 5'd12 && r_xidx < 5'd8) begin
                    n_emit = 1'b1;
                    n_rec.record_kind = KIND_QDC;
                    n_rec.sum_index   = r_xidx[2:0];
                end else if (r_hl == 5'd16 && r_xidx >= 5'd4 && r_xidx < 5'd12) begin
                    n_emit = 1'b1;
                    n_rec.record_kind = KIND_QDC;
                    n_rec.sum_index   = 3'(r_xidx - 5'd4);
                end
                n_xidx = r_xidx + 5'd1;
                if (last) begin
                    k = (el_h > 14'(r_hl)) ? 32'(el_h - 14'(r_hl)) : '0;
                    n_left  = k;
                    n_phase = (k != '0) ? PH_TSKIP : PH_START;
                end else begin
                    n_left = r_left - 32'd1;
                end
            end
            default: begin
                n_phase = PH_START;
            end
        endcase
    end

    // header word capture
    always_ff @(posedge i_clk) begin
        if (take) begin
            if (n_phase == PH_H1 && (r_phase == PH_H0 || r_phase == PH_START)) begin
                r_h0 <= i_word;
            end
            if (r_phase == PH_H1) begin
                r_h1 <= i_word;
            end
            if (r_phase == PH_H2) begin
                r_h2 <= i_word;
            end
        end
        if (take && n_emit) begin
            r_rec <= n_rec;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_START;
            r_left   <= '0;
            r_bsize  <= '0;
            r_bused  <= '0;
            r_evt    <= '1;
            r_xidx   <= '0;
            r_hl     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (take) begin
                r_phase <= n_phase;
                r_left  <= n_left;
                r_bsize <= n_bsize;
                r_bused <= n_bused;
                r_evt   <= n_evt;
                r_xidx  <= n_xidx;
                r_hl    <= n_hl;
            end
            if (take) begin
                r_ovalid <= n_emit;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

endmodule

/* hw/rtl/list_mode_event_word_parser.sv */
// ----------------------------------------------------------------------------
// List-mode event word parser
// Output: a record is held in the framer output register once its last word
// has passed through the word queue and been accepted by the framer.
// Throughput: one word per cycle, queue and framer alike, unless a record waits.
// Two-entry word queue decouples the input from the framer back end.
// Reset: synchronous active low; clears phase, counters, queue, config to 0.
// Event counter resets to all ones so the first event is number 0.
// ----------------------------------------------------------------------------
module list_mode_event_word_parser #(
    parameter int QUEUE_DEPTH = lmewp_pkg::Q_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic        i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_word,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_record_kind,
    output logic [31:0] o_event_number,
    output logic [11:0] o_source_id,
    output logic [4:0]  o_header_length,
    output logic [13:0] o_event_length,
    output logic        o_pileup,
    output logic [47:0] o_timestamp,
    output logic [15:0] o_cfd_word,
    output logic [15:0] o_energy,
    output logic [15:0] o_trace_info,
    output logic [2:0]  o_sum_index,
    output logic [31:0] o_sum_value
);
    import lmewp_pkg::*;

    logic        r_wrapped, r_lengths;
    logic        q_valid, q_ready;
    logic [31:0] q_word;
    t_record     rec;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrapped <= 1'b0;
            r_lengths <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_WRAPPED[0]) begin
                r_wrapped <= i_cfg_data;
            end else begin
                r_lengths <= i_cfg_data;
            end
        end
    end

    lmewp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_word),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_word)
    );

    lmewp_framer u_framer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wrapped (r_wrapped),
        .i_lengths (r_lengths),
        .i_valid   (q_valid),
        .o_ready   (q_ready),
        .i_word    (q_word),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_rec     (rec)
    );

    assign o_record_kind   = rec.record_kind;
    assign o_event_number  = rec.event_number;
    assign o_source_id     = rec.source_id;
    assign o_header_length = rec.header_length;
    assign o_event_length  = rec.event_length;
    assign o_pileup        = rec.pileup;
    assign o_timestamp     = rec.timestamp;
    assign o_cfd_word      = rec.cfd_word;
    assign o_energy        = rec.energy;
    assign o_trace_info    = rec.trace_info;
    assign o_sum_index     = rec.sum_index;
    assign o_sum_value     = rec.sum_value;

endmodule
